// ----- rtl/core/vector4_matrix_transform_core_macros.svh -----
// Assertion macros shared by the vector transform core modules.
`ifndef VECTOR4_MATRIX_TRANSFORM_CORE_MACROS_SVH
`define VECTOR4_MATRIX_TRANSFORM_CORE_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define VMT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define VMT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/vmt_pkg.sv -----
// Types and constants shared by the vector transform core modules.
package vmt_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int DATA_W      = 32;
    localparam int VEC_N       = 4;
    localparam int COEF_N      = VEC_N * VEC_N;
    localparam int COEF_IDX_W  = $clog2(COEF_N);
    localparam int PROD_W      = 2 * DATA_W;
    localparam int PAIR_W      = PROD_W + 1;
    localparam int SUM_W       = PROD_W + 2;

    localparam int IN_FIELDS_W = COEF_IDX_W + DATA_W + VEC_N * DATA_W;
    localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = VEC_N * DATA_W;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    typedef enum logic [0:0] {
        OP_LOAD      = 1'b0,
        OP_TRANSFORM = 1'b1
    } t_op;

    typedef struct packed {
        t_op                          op;
        logic [COEF_IDX_W-1:0]        coef_index;
        logic [DATA_W-1:0]            coef_value;
        logic [VEC_N-1:0][DATA_W-1:0] vec;
    } t_entry;

endpackage

// ----- rtl/core/vmt_front.sv -----
// Front end: takes requests, decodes them into queue entries and buffers them.
`include "vector4_matrix_transform_core_macros.svh"

module vmt_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic                         i_user,
    input  logic [vmt_pkg::IN_TDATA_W-1:0] i_data,
    output logic                         o_valid,
    input  logic                         i_ready,
    output vmt_pkg::t_entry              o_entry
);
    import vmt_pkg::*;

    t_entry              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0]   r_count, n_count;
    t_entry              n_entry;
    logic                w_push, w_pop;

    // Field layout of the request data, lowest bits first.
    always_comb begin
        n_entry.op         = t_op'(i_user);
        n_entry.coef_index = i_data[COEF_IDX_W-1:0];
        n_entry.coef_value = i_data[COEF_IDX_W +: DATA_W];
        for (int i = 0; i < VEC_N; i++) begin
            n_entry.vec[i] = i_data[COEF_IDX_W + DATA_W + i*DATA_W +: DATA_W];
        end
    end

    assign o_ready = (r_count != QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;
    assign o_entry = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        case ({w_push, w_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= n_entry;
        end
    end

    `VMT_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= QCNT_W'(QUEUE_DEPTH), "queue count exceeds depth")
    `VMT_ASSERT_NEXT(a_count_up, i_clk, i_rst_n, w_push && !w_pop, r_count == $past(r_count) + 1'b1, "queue count did not grow on push")
    `VMT_ASSERT_NEXT(a_count_down, i_clk, i_rst_n, w_pop && !w_push, r_count == $past(r_count) - 1'b1, "queue count did not shrink on pop")

endmodule

// ----- rtl/core/vmt_back.sv -----
// Back end: coefficient registers and the multiply, add and saturate pipeline.
`include "vector4_matrix_transform_core_macros.svh"

module vmt_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  vmt_pkg::t_entry               i_entry,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [vmt_pkg::OUT_TDATA_W-1:0] o_data,
    output logic                          o_sat
);
    import vmt_pkg::*;

    logic [DATA_W-1:0]            r_matrix [COEF_N];
    logic signed [PROD_W-1:0]     r_prod   [VEC_N][VEC_N];
    logic signed [PAIR_W-1:0]     r_pair   [VEC_N][2];
    logic signed [SUM_W-1:0]      r_sum    [VEC_N];
    logic signed [SUM_W-1:0]      w_shift  [VEC_N];
    logic [VEC_N-1:0]             w_clamp;
    logic [VEC_N-1:0][DATA_W-1:0] n_out, r_out;
    logic                         n_sat, r_sat;
    logic                         r_v1, r_v2, r_v3, r_out_valid;
    logic                         w_advance, w_pop;

    // The whole pipeline moves unless a finished result is held by the receiver.
    assign w_advance = !r_out_valid || i_ready;
    assign o_ready   = w_advance;
    assign w_pop     = i_valid && w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < COEF_N; k++) begin
                r_matrix[k] <= '0;
            end
        end else if (w_pop && i_entry.op == OP_LOAD) begin
            r_matrix[i_entry.coef_index] <= i_entry.coef_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_v1        <= i_valid && (i_entry.op == OP_TRANSFORM);
            r_v2        <= r_v1;
            r_v3        <= r_v2;
            r_out_valid <= r_v3;
        end
    end

    // Stage 1 products, stage 2 pair sums, stage 3 column sums, stage 4 output.
    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            for (int i = 0; i < VEC_N; i++) begin
                for (int j = 0; j < VEC_N; j++) begin
                    r_prod[i][j] <= PROD_W'($signed(i_entry.vec[i])
                                    * $signed(r_matrix[i*VEC_N + j]));
                end
            end
            for (int j = 0; j < VEC_N; j++) begin
                r_pair[j][0] <= PAIR_W'(r_prod[0][j]) + PAIR_W'(r_prod[1][j]);
                r_pair[j][1] <= PAIR_W'(r_prod[2][j]) + PAIR_W'(r_prod[3][j]);
                r_sum[j]     <= SUM_W'(r_pair[j][0]) + SUM_W'(r_pair[j][1]);
            end
            r_out <= n_out;
            r_sat <= n_sat;
        end
    end

    // The shifted sum fits when every bit from the 32-bit sign bit upward agrees.
    always_comb begin
        for (int j = 0; j < VEC_N; j++) begin
            w_shift[j] = r_sum[j] >>> FRAC_BITS;
            w_clamp[j] = !((&w_shift[j][SUM_W-1:DATA_W-1]) || !(|w_shift[j][SUM_W-1:DATA_W-1]));
            if (!w_clamp[j]) begin
                n_out[j] = w_shift[j][DATA_W-1:0];
            end else if (w_shift[j][SUM_W-1]) begin
                n_out[j] = SAT_MIN;
            end else begin
                n_out[j] = SAT_MAX;
            end
        end
        n_sat = |w_clamp;
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;
    assign o_sat   = r_sat;

    `VMT_ASSERT_NEXT(a_load_no_result, i_clk, i_rst_n, w_pop && i_entry.op == OP_LOAD, !r_v1, "load request entered the arithmetic pipeline")
    `VMT_ASSERT_NEXT(a_stall_holds, i_clk, i_rst_n, !w_advance, r_v1 == $past(r_v1) && r_v2 == $past(r_v2) && r_v3 == $past(r_v3), "pipeline moved while stalled")
    `VMT_ASSERT_NOW(a_sat_value, i_clk, i_rst_n, r_out_valid && r_sat, r_out[0] == SAT_MAX || r_out[0] == SAT_MIN || r_out[1] == SAT_MAX || r_out[1] == SAT_MIN || r_out[2] == SAT_MAX || r_out[2] == SAT_MIN || r_out[3] == SAT_MAX || r_out[3] == SAT_MIN, "saturation flag without a clamped output")

endmodule

// ----- rtl/core/vector4_matrix_transform_core.sv -----
// Top level of the row vector times 4x4 matrix transform core.
//
// Requests arrive on the s_axis channel. s_axis_tuser selects the kind:
// 0 loads one Q16.16 coefficient at a row-major index and gives no result,
// 1 transforms the row vector (x, y, z, w) by the stored matrix.
// Each transform gives one result on m_axis: the four Q16.16 outputs,
// each saturated to 32 bits, with m_axis_tuser set if any was clamped.
// Requests are handled strictly in order, so a load affects every later
// transform and no earlier one.
// Throughput is one request per cycle while s_axis_tready is high.
// A transform result passes through the request queue, then the
// multiplier, pair-sum, column-sum and saturation stages.
// A four-entry queue separates the decode side from the arithmetic pipeline;
// when a result waits with m_axis_tready low the pipeline holds and the
// queue fills, and s_axis_tready drops only once the queue is full.
// Synchronous reset clears the queue, the pipeline and all coefficients
// to zero; no clearing pass is needed.
module vector4_matrix_transform_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // coef_index[3:0], coef_value[35:4], vec_x[67:36], vec_y[99:68],
    // vec_z[131:100], vec_w[163:132], zero pad above
    input  logic [vmt_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // operation
    input  logic                            s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // out_x[31:0], out_y[63:32], out_z[95:64], out_w[127:96]
    output logic [vmt_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    // saturated
    output logic                            m_axis_tuser
);
    import vmt_pkg::*;

    t_entry w_entry;
    logic   w_q_valid, w_q_ready;

    vmt_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_user  (s_axis_tuser),
        .i_data  (s_axis_tdata),
        .o_valid (w_q_valid),
        .i_ready (w_q_ready),
        .o_entry (w_entry)
    );

    vmt_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_q_valid),
        .o_ready (w_q_ready),
        .i_entry (w_entry),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (m_axis_tdata),
        .o_sat   (m_axis_tuser)
    );

endmodule
